/* hdl/cubic_joint_trajectory_top_assert.svh */
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef CUBIC_JOINT_TRAJECTORY_TOP_ASSERT_SVH
`define CUBIC_JOINT_TRAJECTORY_TOP_ASSERT_SVH

// same-cycle implication
`define CJT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define CJT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/cjt_pkg.sv */
package cjt_pkg;

	localparam int JOINT_W    = 3;
	localparam int POS_W      = 10;
	localparam int TIME_W     = 16;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// t^2 and T^2, the (3T - 2t) factor, and the 48-bit cubic terms
	localparam int SQ_W   = 2 * TIME_W;
	localparam int FACT_W = TIME_W + 2;
	localparam int DEN_W  = 3 * TIME_W;
	localparam int HALF_W = DEN_W / 2;

	localparam logic [TIME_W-1:0] DURATION_RESET = 16'd2000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_DURATION = 1'b0;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_POLY1  = 8'b0000_0010,
		ST_POLY2  = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_MUL_LO = 8'b0001_0000,
		ST_MUL_HI = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} cjt_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cjt_div_stat_t;

endpackage

/* hdl/cjt_store.sv */
module cjt_store #(
	parameter int JOINTS        = 5,
	parameter int POSITION_BITS = 10,
	parameter int JW            = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [JW-1:0]            waddr,
	input  logic [POSITION_BITS-1:0] wstart,
	input  logic [POSITION_BITS-1:0] wtarget,
	input  logic [JW-1:0]            raddr,
	output logic [POSITION_BITS-1:0] rstart,
	output logic [POSITION_BITS-1:0] rtarget
);

	localparam int EW = 2 * POSITION_BITS;

	logic [EW-1:0]     mem [JOINTS];
	logic [JOINTS-1:0] vld_q;
	logic [EW-1:0]     rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wtarget, wstart};
		end
		rdata_q <= mem[raddr];
	end

	// entries never written read back as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rstart  = rvld_q ? rdata_q[POSITION_BITS-1:0] : '0;
	assign rtarget = rvld_q ? rdata_q[EW-1:POSITION_BITS] : '0;

endmodule

/* hdl/cjt_div.sv */
module cjt_div #(
	parameter int POSITION_BITS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [POSITION_BITS+cjt_pkg::DEN_W-1:0]  dividend,
	input  logic [cjt_pkg::DEN_W-1:0]                divisor,
	output logic [POSITION_BITS-1:0]                 quo,
	output cjt_pkg::cjt_div_stat_t                   stat
);

	localparam int DW = cjt_pkg::DEN_W;
	localparam int CW = $clog2(POSITION_BITS + 1);

	logic [DW-1:0]            rem_q;
	logic [POSITION_BITS-1:0] low_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     rnd_q;
	logic                     done_q;
	logic [POSITION_BITS-1:0] quo_q;
	logic [DW:0]              r2;
	logic                     ge;
	logic                     up;

	// quotient is known to fit in POSITION_BITS, so the top part starts below the divisor
	assign r2 = {rem_q, low_q[POSITION_BITS-1]};
	assign ge = r2 >= {1'b0, divisor};
	assign up = {rem_q, 1'b0} >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[POSITION_BITS +: DW];
			low_q <= dividend[POSITION_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? DW'(r2 - {1'b0, divisor}) : r2[DW-1:0];
			low_q <= {low_q[POSITION_BITS-2:0], ge};
		end
		if (rnd_q) begin
			quo_q <= low_q + POSITION_BITS'(up);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= rnd_q;
			rnd_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(POSITION_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q | rnd_q;
	assign stat.done = done_q;

endmodule

/* hdl/cubic_joint_trajectory_top.sv */
// load: written straight into the joint memory, no result
// tick with t < T: each joint's offset comes from the restoring divider, one quotient bit
//   per cycle, shared by all joints
// tick with t >= T: targets read straight from the joint memory
// one item in work at a time; the next is taken while the last result waits in the output register
// reset: duration 2000 ms, every joint reads start and target zero, no result pending
`include "cubic_joint_trajectory_top_assert.svh"

module cubic_joint_trajectory_top #(
	parameter int JOINTS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// joint_index, start_position, target_position, elapsed_ms, zero pad
	input  logic [cjt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// operation
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// joint_out, commanded_position, zero pad
	output logic [cjt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// move_done
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cjt_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [cjt_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [cjt_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int PB    = cjt_pkg::POS_W;
	localparam int TW    = cjt_pkg::TIME_W;
	localparam int DW    = cjt_pkg::DEN_W;
	localparam int HW    = cjt_pkg::HALF_W;
	localparam int PRD_W = PB + DW;

	cjt_pkg::cjt_state_t state_q;

	logic [TW-1:0]                  duration_q;
	logic [TW-1:0]                  t_q;
	logic                           done_q;
	logic [cjt_pkg::SQ_W-1:0]       tt_q;
	logic [cjt_pkg::SQ_W-1:0]       tsq_q;
	logic [cjt_pkg::FACT_W-1:0]     fac_q;
	logic [DW-1:0]                  poly_q;
	logic [DW-1:0]                  den_q;
	logic [JW-1:0]                  jcnt_q;
	logic [PB-1:0]                  start_q;
	logic [PB-1:0]                  target_q;
	logic [PB-1:0]                  mag_q;
	logic                           neg_q;
	logic [PB+HW-1:0]               plo_q;

	logic                           m_valid_q;
	logic [cjt_pkg::M_TDATA_W-1:0]  m_data_q;
	logic                           m_user_q;
	logic                           m_last_q;

	logic                           in_xfer;
	logic                           is_load;
	logic                           load_ok;
	logic                           cfg_wr;
	logic [PB-1:0]                  rd_start;
	logic [PB-1:0]                  rd_target;
	logic                           rd_neg;
	logic [PB-1:0]                  rd_mag;
	logic [PRD_W-1:0]               dividend;
	logic                           div_start;
	logic [PB-1:0]                  quo;
	cjt_pkg::cjt_div_stat_t         div_stat;
	logic                           out_load;
	logic                           last_j;
	logic [PB-1:0]                  pos;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == cjt_pkg::REG_DURATION);
	assign prdata = (paddr[2] == cjt_pkg::REG_DURATION) ?
		cjt_pkg::APB_DATA_W'(duration_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= cjt_pkg::DURATION_RESET;
		end else if (cfg_wr) begin
			duration_q <= pwdata[TW-1:0];
		end
	end

	// input side
	assign s_axis_tready = (state_q == cjt_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid & s_axis_tready;
	assign is_load       = (s_axis_tuser == cjt_pkg::OP_LOAD);
	assign load_ok       = in_xfer & is_load &
		({1'b0, s_axis_tdata[2:0]} < (cjt_pkg::JOINT_W + 1)'(JOINTS));

	cjt_store #(
		.JOINTS       (JOINTS),
		.POSITION_BITS(PB),
		.JW           (JW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (load_ok),
		.waddr  (JW'(s_axis_tdata[2:0])),
		.wstart (PB'(s_axis_tdata[12:3])),
		.wtarget(PB'(s_axis_tdata[22:13])),
		.raddr  (jcnt_q),
		.rstart (rd_start),
		.rtarget(rd_target)
	);

	assign rd_neg = rd_target < rd_start;
	assign rd_mag = rd_neg ? (rd_start - rd_target) : (rd_target - rd_start);

	// second half of delta * poly joins the first one on the way into the divider
	assign dividend = ((PRD_W'(mag_q) * PRD_W'(poly_q[DW-1:HW])) << HW) + PRD_W'(plo_q);
	assign div_start = (state_q == cjt_pkg::ST_MUL_HI);

	cjt_div #(
		.POSITION_BITS(PB)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (den_q),
		.quo     (quo),
		.stat    (div_stat)
	);

	assign out_load = (state_q == cjt_pkg::ST_EMIT) & (~m_valid_q | m_axis_tready);
	assign last_j   = (jcnt_q == JW'(JOINTS - 1));
	assign pos      = done_q ? target_q : (neg_q ? (start_q - quo) : (start_q + quo));

	always_ff @(posedge clk) begin
		case (state_q)
			cjt_pkg::ST_IDLE: begin
				t_q <= s_axis_tdata[38:23];
			end
			cjt_pkg::ST_POLY1: begin
				tt_q  <= t_q * t_q;
				tsq_q <= duration_q * duration_q;
				fac_q <= cjt_pkg::FACT_W'({2'b00, duration_q} + {1'b0, duration_q, 1'b0}
					- {1'b0, t_q, 1'b0});
			end
			cjt_pkg::ST_POLY2: begin
				poly_q <= DW'(tt_q * fac_q);
				den_q  <= DW'(tsq_q * duration_q);
			end
			cjt_pkg::ST_MUL_LO: begin
				start_q  <= rd_start;
				target_q <= rd_target;
				mag_q    <= rd_mag;
				neg_q    <= rd_neg;
				plo_q    <= rd_mag * poly_q[HW-1:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_data_q <= cjt_pkg::M_TDATA_W'({cjt_pkg::POS_W'(pos), cjt_pkg::JOINT_W'(jcnt_q)});
			m_user_q <= done_q;
			m_last_q <= last_j;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cjt_pkg::ST_IDLE;
			done_q    <= 1'b0;
			jcnt_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				cjt_pkg::ST_IDLE: begin
					if (in_xfer && !is_load) begin
						done_q  <= s_axis_tdata[38:23] >= duration_q;
						jcnt_q  <= '0;
						state_q <= cjt_pkg::ST_POLY1;
					end
				end
				cjt_pkg::ST_POLY1: state_q <= cjt_pkg::ST_POLY2;
				cjt_pkg::ST_POLY2: state_q <= cjt_pkg::ST_READ;
				cjt_pkg::ST_READ:  state_q <= cjt_pkg::ST_MUL_LO;
				cjt_pkg::ST_MUL_LO: begin
					state_q <= done_q ? cjt_pkg::ST_EMIT : cjt_pkg::ST_MUL_HI;
				end
				cjt_pkg::ST_MUL_HI: state_q <= cjt_pkg::ST_DIV;
				cjt_pkg::ST_DIV: begin
					if (div_stat.done) begin
						state_q <= cjt_pkg::ST_EMIT;
					end
				end
				cjt_pkg::ST_EMIT: begin
					if (out_load) begin
						if (last_j) begin
							state_q <= cjt_pkg::ST_IDLE;
						end else begin
							jcnt_q  <= jcnt_q + 1'b1;
							state_q <= cjt_pkg::ST_READ;
						end
					end
				end
				default: state_q <= cjt_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	`CJT_ASSERT_NOW(a_last_is_final_joint, m_axis_tvalid && m_axis_tlast, m_axis_tdata[2:0] == cjt_pkg::JOINT_W'(JOINTS - 1), "last mark on a joint other than the final one")
	`CJT_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider started while busy")
	`CJT_ASSERT_NEXT(a_out_no_overwrite, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "pending result overwritten")

endmodule

/* tb/cubic_joint_trajectory_top_test.sv */
module cubic_joint_trajectory_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cjt_pkg::*;

	localparam int JOINTS        = 5;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int SEG_ITEMS     = 25;
	localparam int SEGMENTS      = 6;

	localparam logic [APB_ADDR_W-1:0] DURATION_ADDR = {REG_DURATION, 2'b00};
	localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR   = {~REG_DURATION, 2'b00};

	typedef struct packed {
		logic                         op;
		logic [JOINT_W-1:0]           joint;
		logic [POS_W-1:0]             start_pos;
		logic [POS_W-1:0]             target_pos;
		logic [TIME_W-1:0]            elapsed;
		logic                         typed;
		logic                         typed_done;
		logic [JOINTS-1:0][POS_W-1:0] typed_pos;
	} stim_row_t;

	typedef struct packed {
		logic [JOINT_W-1:0] joint;
		logic [POS_W-1:0]   pos;
		logic               done;
		logic               last;
	} joint_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// predictor state
	logic [TIME_W-1:0]     duration_cfg = DURATION_RESET;
	logic [POS_W-1:0]      start_mem [JOINTS];
	logic [POS_W-1:0]      target_mem [JOINTS];
	joint_result_t         pending_positions [$];

	stim_row_t             cur_row = '0;
	stim_row_t             directed_rows [$];
	int unsigned           tx_idle_pct = 0;
	int unsigned           rx_idle_pct = 0;
	bit                    rx_hold = 1'b0;
	event                  hold_ev;
	int unsigned           errors = 0;

	cubic_joint_trajectory_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("cubic_joint_trajectory_top_test: errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// exact cubic blend, rounded half away from zero, only for t < T
	function automatic logic [POS_W-1:0] cubic_position(input logic [POS_W-1:0] from_pos,
			input logic [POS_W-1:0] to_pos, input logic [TIME_W-1:0] t_ms,
			input logic [TIME_W-1:0] dur_ms);
		logic [63:0] t;
		logic [63:0] dur;
		logic [63:0] den;
		logic [63:0] poly;
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] quo;
		logic [63:0] rem;
		logic        down;
		t = 64'(t_ms);
		dur = 64'(dur_ms);
		den = dur * dur * dur;
		poly = t * t * (3 * dur - 2 * t);
		down = to_pos < from_pos;
		mag = down ? 64'(from_pos - to_pos) : 64'(to_pos - from_pos);
		prod = mag * poly;
		quo = prod / den;
		rem = prod % den;
		if (2 * rem >= den) begin
			quo = quo + 1;
		end
		return down ? POS_W'(64'(from_pos) - quo) : POS_W'(64'(from_pos) + quo);
	endfunction

	task automatic apply_item(input stim_row_t r);
		joint_result_t res;
		logic          done;
		if (r.op == OP_LOAD) begin
			if (r.joint < JOINTS) begin
				start_mem[r.joint] = r.start_pos;
				target_mem[r.joint] = r.target_pos;
			end
		end else begin
			done = r.elapsed >= duration_cfg;
			for (int j = 0; j < JOINTS; j++) begin
				res.joint = JOINT_W'(j);
				res.last = (j == JOINTS - 1);
				if (r.typed) begin
					res.done = r.typed_done;
					res.pos = r.typed_pos[j];
				end else begin
					res.done = done;
					res.pos = done ? target_mem[j]
						: cubic_position(start_mem[j], target_mem[j], r.elapsed, duration_cfg);
				end
				pending_positions.push_back(res);
			end
		end
	endtask

	// results are checked before the item taken at the same edge is predicted
	always @(posedge clk) begin : monitor
		joint_result_t got;
		joint_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.joint = m_axis_tdata[JOINT_W-1:0];
			got.pos = m_axis_tdata[JOINT_W +: POS_W];
			got.done = m_axis_tuser;
			got.last = m_axis_tlast;
			if (pending_positions.size() == 0) begin
				report_mismatch("result with nothing pending, position", got.pos, 0);
			end else begin
				want = pending_positions.pop_front();
				if (got.joint !== want.joint)
					report_mismatch("joint_out", got.joint, want.joint);
				if (got.pos !== want.pos)
					report_mismatch("commanded_position", got.pos, want.pos);
				if (got.done !== want.done)
					report_mismatch("move_done", got.done, want.done);
				if (got.last !== want.last)
					report_mismatch("last_joint", got.last, want.last);
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			apply_item(cur_row);
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// long receiver stall, timed here so the sender keeps pushing meanwhile
	initial begin
		forever begin
			@(hold_ev);
			rx_hold = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold = 1'b0;
		end
	end

	task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr && addr[2] == REG_DURATION) begin
			duration_cfg = wdata[TIME_W-1:0];
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_duration(input logic [TIME_W-1:0] dur);
		logic [APB_DATA_W-1:0] rd;
		apb_xfer(1'b1, DURATION_ADDR, APB_DATA_W'(dur), rd);
		apb_xfer(1'b0, DURATION_ADDR, '0, rd);
		if (rd !== APB_DATA_W'(duration_cfg))
			report_mismatch("duration readback", rd, duration_cfg);
	endtask

	task automatic send_row(input stim_row_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		cur_row = r;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.op;
		s_axis_tdata <= {1'b0, r.elapsed, r.target_pos, r.start_pos, r.joint};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	task automatic drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic stim_row_t mk_row(input logic op, input logic [JOINT_W-1:0] joint,
			input logic [POS_W-1:0] from_pos, input logic [POS_W-1:0] to_pos,
			input logic [TIME_W-1:0] t_ms, input logic typed, input logic done,
			input logic [JOINTS-1:0][POS_W-1:0] pos);
		stim_row_t r;
		r.op = op;
		r.joint = joint;
		r.start_pos = from_pos;
		r.target_pos = to_pos;
		r.elapsed = t_ms;
		r.typed = typed;
		r.typed_done = done;
		r.typed_pos = pos;
		return r;
	endfunction

	initial begin : stimulus
		stim_row_t             row;
		logic [APB_DATA_W-1:0] rd;
		int unsigned           dur;
		int unsigned           t_ms;

		for (int j = 0; j < JOINTS; j++) begin
			start_mem[j] = '0;
			target_mem[j] = '0;
		end

		// duration 2000 after reset; typed rows are read straight off the stored pairs
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'd0, 1'b1, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'hFFFF, 1'b1, 1'b1, '0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd0, 10'd0, 10'd1023, 16'd0, 1'b0, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd1, 10'd1023, 10'd0, 16'd0, 1'b0, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd2, 10'd512, 10'd512, 16'd0, 1'b0, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd3, 10'd1023, 10'd1023, 16'd0, 1'b0, 1'b0,
			'0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd4, 10'd100, 10'd900, 16'd0, 1'b0, 1'b0, '0));
		// joints past the last one are dropped
		directed_rows.push_back(mk_row(OP_LOAD, 3'd5, 10'd777, 10'd333, 16'hFFFF, 1'b0, 1'b0,
			'0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd7, 10'd1023, 10'd1023, 16'd0, 1'b0, 1'b0,
			'0));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'd2000, 1'b1, 1'b1,
			{10'd900, 10'd1023, 10'd512, 10'd0, 10'd1023}));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'd0, 1'b1, 1'b0,
			{10'd100, 10'd1023, 10'd512, 10'd1023, 10'd0}));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'd1, 1'b0, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'd1000, 1'b0, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'd1999, 1'b0, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'hFFFF, 1'b1, 1'b1,
			{10'd900, 10'd1023, 10'd512, 10'd0, 10'd1023}));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd6, 10'd0, 10'd1023, 16'd0, 1'b0, 1'b0, '0));
		// tick ignores the load fields
		directed_rows.push_back(mk_row(OP_TICK, 3'd7, 10'd1023, 10'd1023, 16'd500, 1'b0, 1'b0,
			'0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd2, 10'h2AA, 10'h155, 16'hFFFF, 1'b0, 1'b0,
			'0));
		directed_rows.push_back(mk_row(OP_LOAD, 3'd4, 10'h155, 10'h2AA, 16'd0, 1'b0, 1'b0, '0));
		directed_rows.push_back(mk_row(OP_TICK, 3'd0, 10'd0, 10'd0, 16'd1500, 1'b0, 1'b0, '0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 36;
		rx_idle_pct = 50;
		foreach (directed_rows[i]) begin
			send_row(directed_rows[i]);
		end
		drain();

		for (int s = 0; s < SEGMENTS; s++) begin
			case (s)
				0: dur = 1;
				1: dur = 0;
				2: dur = 65535;
				3: dur = 300;
				4: dur = $urandom_range(1, 65535);
				default: dur = $urandom_range(2, 40);
			endcase
			set_duration(TIME_W'(dur));
			if (s == 1) begin
				// write to an unmapped register must leave the duration alone
				apb_xfer(1'b1, UNUSED_ADDR, 32'h0000_FFFF, rd);
			end
			if (s < 2) begin
				tx_idle_pct = 36;
				rx_idle_pct = 50;
			end else if (s < 4) begin
				tx_idle_pct = 50;
				rx_idle_pct = 36;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			for (int i = 0; i < SEG_ITEMS; i++) begin
				row = '0;
				row.op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_TICK;
				row.joint = ($urandom_range(0, 99) < 85) ? JOINT_W'($urandom_range(0, JOINTS - 1))
					: JOINT_W'($urandom_range(JOINTS, 7));
				row.start_pos = ($urandom_range(0, 7) == 0) ? {POS_W{1'($urandom_range(0, 1))}}
					: POS_W'($urandom);
				row.target_pos = ($urandom_range(0, 7) == 0) ? {POS_W{1'($urandom_range(0, 1))}}
					: POS_W'($urandom);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: t_ms = (dur > 0) ? $urandom_range(0, dur - 1) : $urandom_range(0, 65535);
					5: t_ms = (dur > 0) ? dur - 1 : 0;
					6: t_ms = dur;
					7: t_ms = $urandom_range(0, 65535);
					8: t_ms = 0;
					default: begin
						t_ms = dur + $urandom_range(0, 3);
						if (t_ms > 65535) t_ms = 65535;
					end
				endcase
				row.elapsed = TIME_W'(t_ms);
				if (s == 3 && i == 3) begin
					-> hold_ev;
				end
				if (s == 2 && i == 12) begin
					drain();
				end
				send_row(row);
			end
			drain();
		end

		if (errors == 0) begin
			$display("cubic_joint_trajectory_top_test: clean");
		end else begin
			$display("cubic_joint_trajectory_top_test: errors");
		end
		$finish;
	end

endmodule
